@@ hdl/mre_pkg.sv @@
// ----------------------------------------------------------------------------
// mre_pkg
// Shared types and constants for the mouse report to event converter.
// ----------------------------------------------------------------------------
package mre_pkg;

  localparam int FLAG_W      = 10;
  localparam int FLAG_PAD_W  = 16;
  localparam int MAX_RESULTS = 43;
  localparam int IN_W        = 64;
  localparam int OUT_W       = 48;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [11:0] WHEEL_LIMIT = 12'sd1920;

  localparam logic OP_REPORT  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] KIND_DOWN   = 2'd0;
  localparam logic [1:0] KIND_UP     = 2'd1;
  localparam logic [1:0] KIND_GUI    = 2'd2;
  localparam logic [1:0] KIND_MOTION = 2'd3;

  localparam logic [3:0] CODE_NONE       = 4'd0;
  localparam logic [3:0] CODE_WHEEL_BASE = 4'd8;

  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_FILTER_ON   = 2'd1;
  localparam logic [1:0] REG_NO_PRESCALE = 2'd2;
  localparam logic [1:0] REG_GUI_MODE    = 2'd3;

  typedef struct packed {
    logic enable;
    logic filter_on;
    logic no_prescale;
    logic gui_mode;
  } cfg_t;

  typedef struct packed {
    logic                rel_op;
    logic [FLAG_W-1:0]   flags;
    logic                wheel_on;
    logic                axis;
    logic signed [11:0]  amount;
    logic signed [17:0]  x;
    logic signed [16:0]  y;
    logic [2:0]          mods;
  } job_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         code;
    logic signed [17:0] mx;
    logic signed [15:0] my;
    logic [2:0]         mods;
    logic               last;
  } event_t;

endpackage

@@ hdl/mouse_report_to_events_core.sv @@
// ----------------------------------------------------------------------------
// mouse_report_to_events_core
// Converts mouse reports into ordered key, GUI wheel and motion events.
// ----------------------------------------------------------------------------
// A report is taken on the slave stream and queued (two deep) so the input
// keeps flowing while earlier reports are expanded. The back end sequencer
// gives at most one event per cycle while the master side does not stall. It
// walks a setup step, the button slots (2*BUTTONS, down then up for each
// button), one step per wheel event plus one to store the accumulator, and
// one for motion. tlast marks the final event of a report; reports that
// cause no event emit nothing. Config writes are accepted at any time and
// should only be issued while the block is idle.
module mouse_report_to_events_core #(
  parameter int BUTTONS = 5,
  parameter int DETENT  = 120
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // flags[9:0], wheel_vertical, wheel_horizontal, wheel_amount[11:0],
  // move_x[15:0], move_y[15:0], modifiers[2:0], zero pad
  input  logic [mre_pkg::IN_W-1:0]  s_tdata,
  // op
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // code[3:0], motion_x[17:0], motion_y[15:0], mod_out[2:0], zero pad
  output logic [mre_pkg::OUT_W-1:0] m_tdata,
  // kind
  output logic [1:0]                m_tuser,
  output logic                      m_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic                      cfg_data
);
  import mre_pkg::*;

  cfg_t   cfg;
  job_t   job_in;
  job_t   job_out;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  event_t ev;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable      <= 1'b1;
      cfg.filter_on   <= 1'b0;
      cfg.no_prescale <= 1'b0;
      cfg.gui_mode    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:      cfg.enable      <= cfg_data;
        REG_FILTER_ON:   cfg.filter_on   <= cfg_data;
        REG_NO_PRESCALE: cfg.no_prescale <= cfg_data;
        REG_GUI_MODE:    cfg.gui_mode    <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  mre_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .job      (job_in)
  );

  mre_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (job_in),
    .pop   (q_pop),
    .dout  (job_out),
    .full  (q_full),
    .empty (q_empty)
  );

  mre_back #(
    .BUTTONS (BUTTONS),
    .DETENT  (DETENT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (job_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ev    (ev)
  );

  assign m_tdata = {7'b0, ev.mods, ev.my, ev.mx, ev.code};
  assign m_tuser = ev.kind;
  assign m_tlast = ev.last;

endmodule

@@ hdl/mre_front.sv @@
// ----------------------------------------------------------------------------
// mre_front
// Input side: takes reports, drops disabled ones, saturates the wheel,
// scales X (unless prescaling is off) and negates Y, and hands a job to the queue.
// ----------------------------------------------------------------------------
module mre_front (
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [mre_pkg::IN_W-1:0] s_tdata,
  input  logic                    s_tuser,
  input  mre_pkg::cfg_t           cfg,
  input  logic                    q_full,
  output logic                    q_push,
  output mre_pkg::job_t           job
);
  import mre_pkg::*;

  logic [FLAG_W-1:0]  flags;
  logic               wv;
  logic               wh;
  logic signed [11:0] amt;
  logic signed [15:0] mvx;
  logic signed [15:0] mvy;
  logic [2:0]         mods;

  assign flags = s_tdata[9:0];
  assign wv    = s_tdata[10];
  assign wh    = s_tdata[11];
  assign amt   = s_tdata[23:12];
  assign mvx   = s_tdata[39:24];
  assign mvy   = s_tdata[55:40];
  assign mods  = s_tdata[58:56];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && (s_tuser == OP_RELEASE || cfg.enable);

  always_comb begin
    job.rel_op   = (s_tuser == OP_RELEASE);
    job.flags    = flags;
    job.wheel_on = wv || wh;
    job.axis     = !wv;
    if (amt > WHEEL_LIMIT) begin
      job.amount = WHEEL_LIMIT;
    end else if (amt < -WHEEL_LIMIT) begin
      job.amount = -WHEEL_LIMIT;
    end else begin
      job.amount = amt;
    end
    if (cfg.no_prescale) begin
      job.x = 18'(mvx);
    end else begin
      job.x = {mvx, 2'b00};
    end
    job.y    = -(17'(mvy));
    job.mods = mods;
  end

endmodule

@@ hdl/mre_fifo.sv @@
// ----------------------------------------------------------------------------
// mre_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module mre_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mre_pkg::job_t din,
  input  logic          pop,
  output mre_pkg::job_t dout,
  output logic          full,
  output logic          empty
);
  import mre_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/mre_back.sv @@
// ----------------------------------------------------------------------------
// mre_back
// Event sequencer: owns the held mask, wheel accumulators and motion history,
// and walks each job through button slots, wheel detents and motion.
// ----------------------------------------------------------------------------
module mre_back #(
  parameter int BUTTONS = 5,
  parameter int DETENT  = 120
) (
  input  logic             clk,
  input  logic             rst,
  input  mre_pkg::cfg_t    cfg,
  input  mre_pkg::job_t    job,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mre_pkg::event_t  out_ev
);
  import mre_pkg::*;

  localparam int SLOTS     = 2 * BUTTONS;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int WHEEL_CAP = (MAX_RESULTS - 2 * BUTTONS - 1) / 2;
  localparam int CNT_W     = $clog2(2 * WHEEL_CAP + 1);
  localparam int ACC_W     = 13;

  localparam logic [SLOT_W-1:0]      SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic signed [ACC_W-1:0] DET_POS  = ACC_W'(DETENT);
  localparam logic signed [ACC_W-1:0] DET_NEG  = ACC_W'(-DETENT);
  localparam logic signed [ACC_W-1:0] ACC_MAX  = 13'sd2047;
  localparam logic signed [ACC_W-1:0] ACC_MIN  = -13'sd2048;

  typedef enum logic [1:0] {S_IDLE, S_BTN, S_WHEEL, S_MOTION} state_t;

  state_t                   state;
  logic [SLOTS-1:0]         ev;
  logic [SLOT_W-1:0]        slot;
  logic                     whl_on;
  logic                     has_whl;
  logic                     axis;
  logic                     neg;
  logic                     sub;
  logic signed [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]         cnt;
  logic signed [17:0]       mo_x;
  logic signed [15:0]       mo_y;
  logic                     has_mo;
  logic [2:0]               mods;
  logic [BUTTONS-1:0]       held;
  logic signed [11:0]       accum [2];
  logic signed [17:0]       prev_x;
  logic signed [16:0]       prev_y;

  // job setup
  logic [FLAG_PAD_W-1:0]    flags_pad;
  logic [SLOTS-1:0]         ev_p;
  logic [BUTTONS-1:0]       held_p;
  logic signed [ACC_W-1:0]  acc_p;
  logic                     whl_p;
  logic signed [18:0]       sx;
  logic signed [17:0]       sy;
  logic signed [17:0]       ex_p;
  logic signed [16:0]       ey_p;
  logic signed [15:0]       my_p;

  // wheel stepping
  logic signed [ACC_W-1:0]  acc_n;
  logic [CNT_W-1:0]         cnt_n;
  logic [CNT_W-1:0]         cap;
  logic                     more_now;
  logic                     more_next;
  logic signed [11:0]       acc_clamp;
  logic [3:0]               wheel_code;
  logic [SLOTS-1:0]         ev_rest;

  logic                     out_free;
  logic                     emit;
  event_t                   emit_ev;

  always_comb begin
    flags_pad = FLAG_PAD_W'(job.flags);
    for (int i = 0; i < BUTTONS; i++) begin
      if (job.rel_op) begin
        ev_p[2*i]   = 1'b0;
        ev_p[2*i+1] = held[i];
        held_p[i]   = 1'b0;
      end else begin
        ev_p[2*i]   = flags_pad[2*i];
        ev_p[2*i+1] = flags_pad[2*i+1] && (held[i] || flags_pad[2*i]);
        held_p[i]   = (held[i] || flags_pad[2*i]) && !ev_p[2*i+1];
      end
    end

    whl_p = !job.rel_op && job.wheel_on;
    acc_p = ACC_W'(accum[job.axis]) + ACC_W'(job.amount);

    sx = 19'(job.x) + 19'(prev_x);
    sy = 18'(job.y) + 18'(prev_y);
    if (cfg.filter_on) begin
      ex_p = 18'((sx + $signed({18'b0, sx[18]})) >>> 1);
      ey_p = 17'((sy + $signed({17'b0, sy[17]})) >>> 1);
    end else begin
      ex_p = job.x;
      ey_p = job.y;
    end
    if (ey_p > 17'sd32767) begin
      my_p = 16'sh7FFF;
    end else if (ey_p < -17'sd32768) begin
      my_p = -16'sh8000;
    end else begin
      my_p = 16'(ey_p);
    end
  end

  always_comb begin
    acc_n     = neg ? acc + DET_POS : acc + DET_NEG;
    cnt_n     = cnt + 1'b1;
    cap       = cfg.gui_mode ? CNT_W'(2 * WHEEL_CAP) : CNT_W'(WHEEL_CAP);
    more_now  = (acc >= DET_POS || acc <= DET_NEG) && (cnt < cap);
    more_next = (acc_n >= DET_POS || acc_n <= DET_NEG) && (cnt_n < cap);
    if (acc > ACC_MAX) begin
      acc_clamp = 12'sh7FF;
    end else if (acc < ACC_MIN) begin
      acc_clamp = -12'sh800;
    end else begin
      acc_clamp = 12'(acc);
    end
    wheel_code = CODE_WHEEL_BASE | {2'b00, axis, neg};
    ev_rest    = ev & ~(SLOTS'(1) << slot);
  end

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    emit         = 1'b0;
    emit_ev.kind = KIND_DOWN;
    emit_ev.code = CODE_NONE;
    emit_ev.mx   = '0;
    emit_ev.my   = '0;
    emit_ev.mods = '0;
    emit_ev.last = 1'b0;
    case (state)
      S_BTN: begin
        emit         = ev[slot];
        emit_ev.kind = slot[0] ? KIND_UP : KIND_DOWN;
        emit_ev.code = 4'(slot >> 1);
        emit_ev.last = (ev_rest == '0) && !has_whl && !has_mo;
      end
      S_WHEEL: begin
        emit         = whl_on && more_now;
        emit_ev.code = wheel_code;
        if (cfg.gui_mode) begin
          emit_ev.kind = KIND_GUI;
          emit_ev.mods = mods;
          emit_ev.last = !more_next && !has_mo;
        end else if (!sub) begin
          emit_ev.kind = KIND_DOWN;
        end else begin
          emit_ev.kind = KIND_UP;
          emit_ev.last = !more_next && !has_mo;
        end
      end
      S_MOTION: begin
        emit         = has_mo;
        emit_ev.kind = KIND_MOTION;
        emit_ev.mx   = mo_x;
        emit_ev.my   = mo_y;
        emit_ev.last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      held      <= '0;
      accum[0]  <= '0;
      accum[1]  <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      ev        <= '0;
      slot      <= '0;
      whl_on    <= 1'b0;
      has_whl   <= 1'b0;
      has_mo    <= 1'b0;
      sub       <= 1'b0;
      cnt       <= '0;
    end else begin
      if (emit && out_free) begin
        out_valid <= 1'b1;
        out_ev    <= emit_ev;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ev      <= ev_p;
            held    <= held_p;
            slot    <= '0;
            whl_on  <= whl_p;
            has_whl <= whl_p && (acc_p >= DET_POS || acc_p <= DET_NEG);
            axis    <= job.axis;
            acc     <= acc_p;
            neg     <= acc_p < 0;
            cnt     <= '0;
            sub     <= 1'b0;
            mods    <= job.mods;
            mo_x    <= ex_p;
            mo_y    <= my_p;
            has_mo  <= !job.rel_op && (ex_p != 0 || ey_p != 0);
            if (job.rel_op) begin
              accum[0] <= '0;
              accum[1] <= '0;
            end else begin
              prev_x <= job.x;
              prev_y <= job.y;
            end
            state <= S_BTN;
          end
        end
        S_BTN: begin
          if (!ev[slot] || out_free) begin
            ev[slot] <= 1'b0;
            if (slot == SLOT_LAST) begin
              state <= S_WHEEL;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        S_WHEEL: begin
          if (whl_on && more_now) begin
            if (out_free) begin
              if (cfg.gui_mode || sub) begin
                acc <= acc_n;
                cnt <= cnt_n;
                sub <= 1'b0;
              end else begin
                sub <= 1'b1;
              end
            end
          end else begin
            if (whl_on) begin
              accum[axis] <= acc_clamp;
            end
            state <= S_MOTION;
          end
        end
        S_MOTION: begin
          if (!has_mo || out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/mouse_event_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mouse_event_checker
// Watches the report, event and register channels of the mouse report
// converter. Keeps its own copy of the registers, the held buttons, the wheel
// accumulators and the motion history. Expands every accepted report into the
// events it should produce and compares each accepted event beat in order.
// ----------------------------------------------------------------------------
module mouse_event_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [mre_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tuser,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [mre_pkg::OUT_W-1:0] m_tdata,
  input  logic [1:0]                m_tuser,
  input  logic                      m_tlast,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic                      cfg_data,
  output int                        errors,
  output int                        pending,
  output int                        checked
);

  import mre_pkg::*;

  localparam int BUTTONS    = 5;
  localparam int DETENT     = 120;
  localparam int DETENT_CAP = (MAX_RESULTS - 2 * BUTTONS - 1) / 2;
  localparam int MAX_REPORTS_SHOWN = 40;

  logic               en_r, filter_r, no_prescale_r, gui_r;
  logic [BUTTONS-1:0] held;
  int                 wheel_acc [2];
  int                 prev_x, prev_y;
  int                 report_events;
  event_t             expected_events [$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic void add_event(logic [1:0] kind, logic [3:0] code, int mx, int my,
                                    logic [2:0] mods);
    event_t e;
    if (report_events >= MAX_RESULTS) return;
    e.kind = kind;
    e.code = code;
    e.mx   = mx[17:0];
    e.my   = my[15:0];
    e.mods = mods;
    e.last = 1'b0;
    expected_events.push_back(e);
    report_events++;
  endfunction

  task automatic expand_report(input logic op, input logic [IN_W-1:0] d);
    logic [FLAG_W-1:0] flags;
    logic [2:0]        mods;
    logic [3:0]        code;
    int                axis, amt, acc, step, cnt, cap, x, y, ex, ey;
    event_t            e;
    flags = d[9:0];
    amt   = $signed(d[23:12]);
    x     = $signed(d[39:24]);
    y     = $signed(d[55:40]);
    mods  = d[58:56];
    report_events = 0;
    if (op == OP_RELEASE) begin
      for (int i = 0; i < BUTTONS; i++)
        if (held[i]) add_event(KIND_UP, i[3:0], 0, 0, 3'd0);
      held = '0;
      wheel_acc[0] = 0;
      wheel_acc[1] = 0;
    end else if (en_r) begin
      for (int i = 0; i < BUTTONS; i++) begin
        if (flags[2*i]) begin
          held[i] = 1'b1;
          add_event(KIND_DOWN, i[3:0], 0, 0, 3'd0);
        end
        if (flags[2*i+1] && held[i]) begin
          held[i] = 1'b0;
          add_event(KIND_UP, i[3:0], 0, 0, 3'd0);
        end
      end
      if (d[10] || d[11]) begin
        // vertical wins when both wheels are flagged
        axis = d[10] ? 0 : 1;
        if (amt > int'(WHEEL_LIMIT)) amt = int'(WHEEL_LIMIT);
        if (amt < -int'(WHEEL_LIMIT)) amt = -int'(WHEEL_LIMIT);
        acc = wheel_acc[axis] + amt;
        if (acc < 0) begin
          step = DETENT;
          code = CODE_WHEEL_BASE + 4'd1;
        end else begin
          step = -DETENT;
          code = CODE_WHEEL_BASE;
        end
        if (axis == 1) code = code + 4'd2;
        cnt = 0;
        cap = gui_r ? 2 * DETENT_CAP : DETENT_CAP;
        while ((acc >= DETENT || acc <= -DETENT) && cnt < cap) begin
          if (gui_r) begin
            add_event(KIND_GUI, code, 0, 0, mods);
          end else begin
            add_event(KIND_DOWN, code, 0, 0, 3'd0);
            add_event(KIND_UP, code, 0, 0, 3'd0);
          end
          acc += step;
          cnt++;
        end
        if (acc > 2047) acc = 2047;
        if (acc < -2048) acc = -2048;
        wheel_acc[axis] = acc;
      end
      if (!no_prescale_r) x = x * 4;
      y = -y;
      // SV division truncates toward zero
      ex = filter_r ? (x + prev_x) / 2 : x;
      ey = filter_r ? (y + prev_y) / 2 : y;
      prev_x = x;
      prev_y = y;
      if (ex != 0 || ey != 0) begin
        if (ey > 32767) ey = 32767;
        if (ey < -32768) ey = -32768;
        add_event(KIND_MOTION, CODE_NONE, ex, ey, 3'd0);
      end
    end
    if (report_events > 0) begin
      e = expected_events.pop_back();
      e.last = 1'b1;
      expected_events.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    event_t got, want;
    if (rst) begin
      en_r          = 1'b1;
      filter_r      = 1'b0;
      no_prescale_r = 1'b0;
      gui_r         = 1'b0;
      held          = '0;
      wheel_acc[0]  = 0;
      wheel_acc[1]  = 0;
      prev_x        = 0;
      prev_y        = 0;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:      en_r          = cfg_data;
          REG_FILTER_ON:   filter_r      = cfg_data;
          REG_NO_PRESCALE: no_prescale_r = cfg_data;
          REG_GUI_MODE:    gui_r         = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expand_report(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.code = m_tdata[3:0];
        got.mx   = m_tdata[21:4];
        got.my   = m_tdata[37:22];
        got.mods = m_tdata[40:38];
        got.last = m_tlast;
        if (expected_events.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS_SHOWN)
            $display("%0t: unexpected event beat kind %0d code %0d x %0d y %0d mods %0d last %0d",
                     $time, got.kind, got.code, got.mx, got.my, got.mods, got.last);
        end else begin
          want = expected_events.pop_front();
          checked++;
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS_SHOWN)
              $display({"%0t: event mismatch: expected kind %0d code %0d x %0d y %0d mods %0d",
                        " last %0d, actual kind %0d code %0d x %0d y %0d mods %0d last %0d"},
                       $time, want.kind, want.code, want.mx, want.my, want.mods, want.last,
                       got.kind, got.code, got.mx, got.my, got.mods, got.last);
          end
        end
      end
    end
    pending <= expected_events.size();
  end

endmodule

@@ tb/mouse_report_to_events_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mouse_report_to_events_core_tb
// Drives reports and register writes into the mouse report converter.
// A directed pass covers button, wheel, motion and release corner cases, then
// randomized phases run under several register settings with random idle
// bursts on both streams and one long output stall. Checking is done by
// mouse_event_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module mouse_report_to_events_core_tb;

  import mre_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 300;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              s_tvalid   = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata    = '0;
  logic              s_tuser    = OP_REPORT;
  logic              m_tvalid;
  logic              m_tready   = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index  = REG_ENABLE;
  logic              cfg_data   = 1'b0;

  logic              tx_idle    = 1'b1;
  logic              rx_idle    = 1'b1;
  logic              hold_req   = 1'b0;
  int                cycles     = 0;
  int                reports_sent  = 0;
  int                settings_used = 0;
  int                errors, pending, checked;

  mouse_report_to_events_core uut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  mouse_event_checker chk (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .checked
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // event sink: random short stalls, or one long stall on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req <= 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [IN_W-1:0] report(logic [FLAG_W-1:0] flags, logic wv, logic wh,
                                             logic [11:0] amt, logic [15:0] mx,
                                             logic [15:0] my, logic [2:0] mods);
    return {5'b0, mods, my, mx, amt, wh, wv, flags};
  endfunction

  function automatic logic [15:0] rand_motion();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return 16'(int'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(input logic op, input logic [IN_W-1:0] data);
    s_tuser  <= op;
    s_tdata  <= data;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reports_sent++;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic              op;
    logic [FLAG_W-1:0] flags;
    logic              wv, wh;
    logic [11:0]       amt;
    op = ($urandom_range(0, 11) == 0) ? OP_RELEASE : OP_REPORT;
    case ($urandom_range(0, 2))
      0:       flags = FLAG_W'($urandom);
      1:       flags = FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
      default: flags = '0;
    endcase
    wv  = 1'b0;
    wh  = 1'b0;
    amt = 12'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 2))
        0:       wv = 1'b1;
        1:       wh = 1'b1;
        default: {wv, wh} = 2'b11;
      endcase
      case ($urandom_range(0, 2))
        0:       amt = 12'(120 * (int'($urandom_range(0, 32)) - 16));
        1:       amt = 12'(int'($urandom_range(0, 400)) - 200);
        default: amt = 12'($urandom);
      endcase
    end
    send(op, report(flags, wv, wh, amt, rand_motion(), rand_motion(), 3'($urandom)));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] regs);
    logic [1:0] order [4];
    order = '{REG_ENABLE, REG_FILTER_ON, REG_NO_PRESCALE, REG_GUI_MODE};
    for (int r = 0; r < 4; r++) begin
      cfg_index <= order[r];
      cfg_data  <= regs[order[r]];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic en, input logic filt, input logic nps, input logic gui,
                           input int count, input logic hold);
    logic [3:0] regs;
    regs[REG_ENABLE]      = en;
    regs[REG_FILTER_ON]   = filt;
    regs[REG_NO_PRESCALE] = nps;
    regs[REG_GUI_MODE]    = gui;
    wait_idle();
    set_config(regs);
    for (int k = 0; k < count; k++) begin
      if (hold && k == count / 2) hold_req <= 1'b1;
      send_random();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    send(OP_REPORT, report(10'h000, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h155, 1'b0, 1'b0, 12'd0, 16'h7FFF, 16'h8000, 3'd0));
    send(OP_REPORT, report(10'h2AA, 1'b0, 1'b0, 12'd0, 16'h8000, 16'h7FFF, 3'd0));
    send(OP_REPORT, report(10'h002, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd7));
    send(OP_REPORT, report(10'h3FF, 1'b0, 1'b0, 12'd0, 16'h0001, 16'hFFFF, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b1, 1'b0, 12'd1920, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b1, 1'b1, 12'h800, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b0, 1'b1, 12'd119, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b0, 1'b1, 12'd1, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b0, 1'b1, -12'sd120, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b1, 1'b0, 12'h7FF, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h001, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h100, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd0));
    send(OP_RELEASE, report(10'h3FF, 1'b1, 1'b1, 12'h7FF, 16'h1234, 16'h8000, 3'd7));
    send(OP_RELEASE, report(10'h000, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b1, 1'b0, 12'd60, 16'h0000, 16'h0000, 3'd0));
    send(OP_RELEASE, report(10'h000, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b1, 1'b0, 12'd60, 16'h0000, 16'h0000, 3'd0));

    // GUI wheel, filter and unscaled X
    wait_idle();
    set_config(4'b1111);
    send(OP_REPORT, report(10'h004, 1'b1, 1'b0, 12'd240, 16'h0000, 16'h0000, 3'd7));
    send(OP_REPORT, report(10'h000, 1'b0, 1'b1, -12'sd360, 16'h0001, 16'h0000, 3'd5));
    send(OP_REPORT, report(10'h000, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd0));
    send(OP_REPORT, report(10'h000, 1'b0, 1'b0, 12'd0, 16'hFFFF, 16'h0000, 3'd0));

    // disabled: reports dropped, release still acts
    wait_idle();
    set_config(4'b1110);
    send(OP_REPORT, report(10'h155, 1'b1, 1'b0, 12'd480, 16'h0100, 16'h0100, 3'd0));
    send(OP_RELEASE, report(10'h000, 1'b0, 1'b0, 12'd0, 16'h0000, 16'h0000, 3'd0));

    run_phase(1'b1, 1'b0, 1'b0, 1'b0, 90, 1'b0);
    run_phase(1'b1, 1'b1, 1'b1, 1'b1, 90, 1'b1);
    run_phase(1'b1, 1'b0, 1'b1, 1'b1, 90, 1'b0);
    run_phase(1'b1, 1'b1, 1'b0, 1'b0, 90, 1'b0);
    run_phase(1'b0, 1'b1, 1'b1, 1'b1, 20, 1'b0);
    wait_idle();
    tx_idle <= 1'b0;
    rx_idle <= 1'b0;
    run_phase(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 100, 1'b0);
    wait_idle();

    $display("%0d reports sent under %0d register settings, %0d event beats checked",
             reports_sent, settings_used, checked);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
